// ===== sv/mclm_pkg.sv =====
// Shared types, constants and codes of the multi-channel liveness monitor.
`default_nettype none
package mclm_pkg;

   localparam int CHANNELS    = 8;
   localparam int TIME_BITS   = 32;
   localparam int CH_IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // field widths
   localparam int OP_BITS    = 2;
   localparam int CH_BITS    = 3;
   localparam int MASK_BITS  = 8;
   localparam int TOP_BITS   = 4;
   localparam int LIMIT_BITS = 8;
   localparam int PRIO_BITS  = 4;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 64;

   // operation codes
   localparam logic [OP_BITS-1:0] OP_TICK    = 2'd0;
   localparam logic [OP_BITS-1:0] OP_SCAN    = 2'd1;
   localparam logic [OP_BITS-1:0] OP_ARRIVAL = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_OFFLINE  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_SETTLE   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_PRIO     = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_ENABLE   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_CHECK    = 3'd4;

   // register reset values
   localparam logic [CHANNELS*LIMIT_BITS-1:0] OFFLINE_RESET =
      (CHANNELS*LIMIT_BITS)'(64'd723401728249833572);
   localparam logic [CHANNELS*LIMIT_BITS-1:0] SETTLE_RESET =
      (CHANNELS*LIMIT_BITS)'(64'd723401728265300008);
   localparam logic [CHANNELS*PRIO_BITS-1:0] PRIO_RESET =
      (CHANNELS*PRIO_BITS)'(32'd1450753246);
   localparam logic [CHANNELS-1:0] ENABLE_RESET = CHANNELS'(8'd255);
   localparam logic [CHANNELS-1:0] CHECK_RESET  = CHANNELS'(8'd4);

   localparam logic [TOP_BITS-1:0] NO_CHANNEL = 4'd8;

   // per-channel verdict of the shared age comparator
   typedef struct packed {
      logic offline;
      logic settling;
   } age_result_type;

endpackage
`default_nettype wire

// ===== sv/multi_channel_liveness_monitor.sv =====
// Top level of the multi-channel liveness monitor: sequencer, state and registers.
`default_nettype none
// Usage
//   Input: drive req_operation, req_channel, req_data_bad with start high; the
//   transaction is taken at a rising edge where start is high and busy is low.
//   Busy stays low for tick and arrival transactions.
//   A scan walks the channels one per cycle through a single shared age
//   comparator, so busy is high until the last channel is done and the next
//   transaction can be taken right after.
//   Result: rsp_valid pulses for one cycle with rsp_lost_mask, rsp_error_mask
//   and rsp_top_channel; it appears in the cycle after a tick or arrival is
//   taken and in the cycle after the last scan step. Every transaction,
//   including an unused operation code, yields exactly one result. The
//   receiver cannot stall; results are never held.
//   Configuration: csr_valid/csr_ready write channel, index 0 offline limits,
//   1 settle windows, 2 priorities, 3 enable mask, 4 check mask; csr_ready is
//   always high. Write only while no transaction is in flight.
//   Reset (synchronous, active high): time and stamps to zero, all channels
//   marked lost, in error and data-bad, no top channel, registers to defaults.
module multi_channel_liveness_monitor (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [mclm_pkg::OP_BITS-1:0]        req_operation,
   input  wire logic [mclm_pkg::CH_BITS-1:0]        req_channel,
   input  wire logic                                req_data_bad,
   output logic                                     rsp_valid,
   output logic [mclm_pkg::MASK_BITS-1:0]           rsp_lost_mask,
   output logic [mclm_pkg::MASK_BITS-1:0]           rsp_error_mask,
   output logic [mclm_pkg::TOP_BITS-1:0]            rsp_top_channel,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [mclm_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [mclm_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int NCH = mclm_pkg::CHANNELS;
   localparam int IW  = mclm_pkg::CH_IDX_BITS;
   localparam int TW  = mclm_pkg::TIME_BITS;

   // sequencer states
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic rsp_valid_ff, rsp_valid_in;

   // configuration registers
   logic [NCH*mclm_pkg::LIMIT_BITS-1:0] offline_ff;
   logic [NCH*mclm_pkg::LIMIT_BITS-1:0] settle_ff;
   logic [NCH*mclm_pkg::PRIO_BITS-1:0]  prio_ff;
   logic [NCH-1:0]                      enable_ff;
   logic [NCH-1:0]                      check_ff;

   // monitor state
   logic [TW-1:0]  time_ff;
   logic [TW-1:0]  last_arrival_ff [NCH];
   logic [TW-1:0]  work_start_ff [NCH];
   logic [NCH-1:0] lost_ff, lost_in;
   logic [NCH-1:0] error_ff, error_in;
   logic [NCH-1:0] bad_ff, bad_in;
   logic [mclm_pkg::TOP_BITS-1:0]  top_ff, top_in;
   logic [mclm_pkg::TOP_BITS-1:0]  best_ff, best_in;
   logic [mclm_pkg::PRIO_BITS-1:0] best_prio_ff, best_prio_in;

   logic                                accept;
   logic                                scan_step;
   logic                                scan_last;
   logic                                arrive;
   logic [IW-1:0]                       arr_idx;
   logic [mclm_pkg::PRIO_BITS-1:0]      cur_prio;
   mclm_pkg::age_result_type            age_res;

   assign accept    = start && !busy;
   assign scan_step = (state_ff == ST_SCAN);
   assign scan_last = scan_step && (idx_ff == IW'(NCH - 1));
   assign arr_idx   = req_channel[IW-1:0];
   // an arrival on a channel beyond the built count is dropped
   assign arrive    = accept && (req_operation == mclm_pkg::OP_ARRIVAL)
                      && ({1'b0, req_channel} < 4'(NCH));
   assign cur_prio  = prio_ff[idx_ff*mclm_pkg::PRIO_BITS +: mclm_pkg::PRIO_BITS];

   // one comparator serves every channel, stepped by the scan index
   mclm_age_unit u_age (
      .now_time      (time_ff),
      .last_time     (last_arrival_ff[idx_ff]),
      .start_time    (work_start_ff[idx_ff]),
      .offline_limit (offline_ff[idx_ff*mclm_pkg::LIMIT_BITS +: mclm_pkg::LIMIT_BITS]),
      .settle_limit  (settle_ff[idx_ff*mclm_pkg::LIMIT_BITS +: mclm_pkg::LIMIT_BITS]),
      .result        (age_res)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (accept) begin
               if (req_operation == mclm_pkg::OP_SCAN) begin
                  state_in = ST_SCAN;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            idx_in = idx_ff + 1'b1;
            if (scan_last) begin
               state_in     = ST_IDLE;
               idx_in       = '0;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // flag updates: one channel per scan step, or the arriving channel
   always_comb begin
      lost_in      = lost_ff;
      error_in     = error_ff;
      bad_in       = bad_ff;
      top_in       = top_ff;
      best_in      = best_ff;
      best_prio_in = best_prio_ff;
      if (accept && req_operation == mclm_pkg::OP_SCAN) begin
         best_in      = mclm_pkg::NO_CHANNEL;
         best_prio_in = '0;
      end
      if (arrive) begin
         lost_in[arr_idx] = 1'b0;
         if (check_ff[arr_idx] && req_data_bad) begin
            error_in[arr_idx] = 1'b1;
            bad_in[arr_idx]   = 1'b1;
         end else begin
            bad_in[arr_idx] = 1'b0;
         end
      end
      if (scan_step && enable_ff[idx_ff]) begin
         if (age_res.offline) begin
            // an existing error keeps both marks as they are
            if (!error_ff[idx_ff]) begin
               lost_in[idx_ff]  = 1'b1;
               error_in[idx_ff] = 1'b1;
            end
            // strict compare keeps the lowest index on a tie
            if (cur_prio > best_prio_ff) begin
               best_prio_in = cur_prio;
               best_in      = mclm_pkg::TOP_BITS'(idx_ff);
            end
         end else if (age_res.settling) begin
            lost_in[idx_ff]  = 1'b0;
            error_in[idx_ff] = 1'b1;
         end else begin
            lost_in[idx_ff]  = 1'b0;
            error_in[idx_ff] = bad_ff[idx_ff];
         end
      end
      if (scan_last) begin
         top_in = best_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         offline_ff   <= mclm_pkg::OFFLINE_RESET;
         settle_ff    <= mclm_pkg::SETTLE_RESET;
         prio_ff      <= mclm_pkg::PRIO_RESET;
         enable_ff    <= mclm_pkg::ENABLE_RESET;
         check_ff     <= mclm_pkg::CHECK_RESET;
         time_ff      <= '0;
         lost_ff      <= '1;
         error_ff     <= '1;
         bad_ff       <= '1;
         top_ff       <= mclm_pkg::NO_CHANNEL;
         best_ff      <= mclm_pkg::NO_CHANNEL;
         best_prio_ff <= '0;
         for (int n = 0; n < NCH; n++) begin
            last_arrival_ff[n] <= '0;
            work_start_ff[n]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         lost_ff      <= lost_in;
         error_ff     <= error_in;
         bad_ff       <= bad_in;
         top_ff       <= top_in;
         best_ff      <= best_in;
         best_prio_ff <= best_prio_in;
         if (accept && req_operation == mclm_pkg::OP_TICK) begin
            time_ff <= time_ff + 1'b1;
         end
         if (arrive) begin
            last_arrival_ff[arr_idx] <= time_ff;
            // restart the settle window on reconnect
            if (lost_ff[arr_idx]) begin
               work_start_ff[arr_idx] <= time_ff;
            end
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               mclm_pkg::REG_OFFLINE: offline_ff <= (NCH*mclm_pkg::LIMIT_BITS)'(csr_wdata);
               mclm_pkg::REG_SETTLE:  settle_ff  <= (NCH*mclm_pkg::LIMIT_BITS)'(csr_wdata);
               mclm_pkg::REG_PRIO:    prio_ff    <= (NCH*mclm_pkg::PRIO_BITS)'(csr_wdata);
               mclm_pkg::REG_ENABLE:  enable_ff  <= NCH'(csr_wdata);
               mclm_pkg::REG_CHECK:   check_ff   <= NCH'(csr_wdata);
               default: begin
                  // drop writes to unmapped indexes
               end
            endcase
         end
      end
   end

   assign busy            = scan_step;
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_lost_mask   = mclm_pkg::MASK_BITS'(lost_ff);
   assign rsp_error_mask  = mclm_pkg::MASK_BITS'(error_ff);
   assign rsp_top_channel = top_ff;

endmodule
`default_nettype wire

// ===== sv/mclm_age_unit.sv =====
// Shared age comparator: offline and settle-window checks for one channel.
`default_nettype none
module mclm_age_unit (
   input  wire logic [mclm_pkg::TIME_BITS-1:0]  now_time,
   input  wire logic [mclm_pkg::TIME_BITS-1:0]  last_time,
   input  wire logic [mclm_pkg::TIME_BITS-1:0]  start_time,
   input  wire logic [mclm_pkg::LIMIT_BITS-1:0] offline_limit,
   input  wire logic [mclm_pkg::LIMIT_BITS-1:0] settle_limit,
   output mclm_pkg::age_result_type             result
);

   logic [mclm_pkg::TIME_BITS-1:0] age;
   logic [mclm_pkg::TIME_BITS-1:0] since;

   // modular subtraction wraps with the clock
   assign age   = now_time - last_time;
   assign since = now_time - start_time;

   assign result.offline  = age > mclm_pkg::TIME_BITS'(offline_limit);
   assign result.settling = since < mclm_pkg::TIME_BITS'(settle_limit);

endmodule
`default_nettype wire

// ===== bench/multi_channel_liveness_monitor_tb.sv =====
// Self-checking testbench for the multi-channel liveness monitor.
`timescale 1ns / 100ps

module multi_channel_liveness_monitor_tb;

   // Operation code 3 is unused: the block must answer it with unchanged status.
   localparam logic [mclm_pkg::OP_BITS-1:0] OP_NONE = 2'd3;
   localparam int CYCLE_LIMIT = 200_000;
   localparam int SETTLE_CYCLES = 12;

   typedef struct packed {
      logic [mclm_pkg::OP_BITS-1:0] op;
      logic [mclm_pkg::CH_BITS-1:0] ch;
      logic                         bad;
   } watch_req_type;

   typedef struct packed {
      logic [mclm_pkg::MASK_BITS-1:0] lost;
      logic [mclm_pkg::MASK_BITS-1:0] err;
      logic [mclm_pkg::TOP_BITS-1:0]  top;
   } status_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [mclm_pkg::OP_BITS-1:0]       req_operation = '0;
   logic [mclm_pkg::CH_BITS-1:0]       req_channel = '0;
   logic                               req_data_bad = 1'b0;
   logic                               rsp_valid;
   logic [mclm_pkg::MASK_BITS-1:0]     rsp_lost_mask;
   logic [mclm_pkg::MASK_BITS-1:0]     rsp_error_mask;
   logic [mclm_pkg::TOP_BITS-1:0]      rsp_top_channel;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [mclm_pkg::CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [mclm_pkg::CSR_DATA_BITS-1:0] csr_wdata = '0;

   // Transactions waiting to be driven, and status words the block still owes.
   watch_req_type pending_reqs[$];
   status_type    status_due[$];
   logic          steady = 1'b0;   // set to suppress sender idling for a whole phase
   int            errors_seen = 0;
   int            cycle_count = 0;

   // Shadow copy of the registers and the watchdog state.
   logic [mclm_pkg::CHANNELS*mclm_pkg::LIMIT_BITS-1:0] offline_cfg;
   logic [mclm_pkg::CHANNELS*mclm_pkg::LIMIT_BITS-1:0] settle_cfg;
   logic [mclm_pkg::CHANNELS*mclm_pkg::PRIO_BITS-1:0]  prio_cfg;
   logic [mclm_pkg::CHANNELS-1:0]                      enable_cfg;
   logic [mclm_pkg::CHANNELS-1:0]                      check_cfg;
   logic [mclm_pkg::TIME_BITS-1:0]                     now_ticks;
   logic [mclm_pkg::TIME_BITS-1:0]                     seen_at[mclm_pkg::CHANNELS];
   logic [mclm_pkg::TIME_BITS-1:0]                     settle_from[mclm_pkg::CHANNELS];
   logic [mclm_pkg::CHANNELS-1:0]                      lost_bits;
   logic [mclm_pkg::CHANNELS-1:0]                      err_bits;
   logic [mclm_pkg::CHANNELS-1:0]                      bad_bits;
   logic [mclm_pkg::TOP_BITS-1:0]                      top_chan;

   multi_channel_liveness_monitor dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_channel     (req_channel),
      .req_data_bad    (req_data_bad),
      .rsp_valid       (rsp_valid),
      .rsp_lost_mask   (rsp_lost_mask),
      .rsp_error_mask  (rsp_error_mask),
      .rsp_top_channel (rsp_top_channel),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void reset_watchdog();
      offline_cfg = mclm_pkg::OFFLINE_RESET;
      settle_cfg  = mclm_pkg::SETTLE_RESET;
      prio_cfg    = mclm_pkg::PRIO_RESET;
      enable_cfg  = mclm_pkg::ENABLE_RESET;
      check_cfg   = mclm_pkg::CHECK_RESET;
      now_ticks   = '0;
      for (int n = 0; n < mclm_pkg::CHANNELS; n++) begin
         seen_at[n]     = '0;
         settle_from[n] = '0;
      end
      lost_bits = '1;
      err_bits  = '1;
      bad_bits  = '1;
      top_chan  = mclm_pkg::NO_CHANNEL;
   endfunction

   // Walk every enabled channel: offline ones go lost (unless already in error)
   // and compete for top priority; online ones hold error while settling,
   // then follow their data-bad mark.
   function automatic void scan_channels();
      logic [mclm_pkg::TOP_BITS-1:0]   best;
      logic [mclm_pkg::PRIO_BITS-1:0]  best_prio;
      logic [mclm_pkg::TIME_BITS-1:0]  age;
      logic [mclm_pkg::TIME_BITS-1:0]  since;
      logic [mclm_pkg::LIMIT_BITS-1:0] off_lim;
      logic [mclm_pkg::LIMIT_BITS-1:0] set_lim;
      logic [mclm_pkg::PRIO_BITS-1:0]  prio;
      best      = mclm_pkg::NO_CHANNEL;
      best_prio = '0;
      for (int n = 0; n < mclm_pkg::CHANNELS; n++) begin
         off_lim = offline_cfg[mclm_pkg::LIMIT_BITS*n +: mclm_pkg::LIMIT_BITS];
         set_lim = settle_cfg[mclm_pkg::LIMIT_BITS*n +: mclm_pkg::LIMIT_BITS];
         prio    = prio_cfg[mclm_pkg::PRIO_BITS*n +: mclm_pkg::PRIO_BITS];
         age     = now_ticks - seen_at[n];
         since   = now_ticks - settle_from[n];
         if (enable_cfg[n]) begin
            if (age > mclm_pkg::TIME_BITS'(off_lim)) begin
               if (!err_bits[n]) begin
                  lost_bits[n] = 1'b1;
                  err_bits[n]  = 1'b1;
               end
               // strict compare: ties keep the lower index, priority 0 never wins
               if (prio > best_prio) begin
                  best_prio = prio;
                  best      = mclm_pkg::TOP_BITS'(n);
               end
            end else if (since < mclm_pkg::TIME_BITS'(set_lim)) begin
               lost_bits[n] = 1'b0;
               err_bits[n]  = 1'b1;
            end else begin
               lost_bits[n] = 1'b0;
               err_bits[n]  = bad_bits[n];
            end
         end
      end
      top_chan = best;
   endfunction

   // Apply one accepted transaction and queue the status it must produce.
   function automatic void advance_watchdog(watch_req_type r);
      status_type s;
      case (r.op)
         mclm_pkg::OP_TICK: now_ticks = now_ticks + 1'b1;
         mclm_pkg::OP_SCAN: scan_channels();
         mclm_pkg::OP_ARRIVAL: begin
            seen_at[r.ch] = now_ticks;
            if (lost_bits[r.ch]) begin
               lost_bits[r.ch]   = 1'b0;
               settle_from[r.ch] = now_ticks;
            end
            if (check_cfg[r.ch] && r.bad) begin
               err_bits[r.ch] = 1'b1;
               bad_bits[r.ch] = 1'b1;
            end else begin
               bad_bits[r.ch] = 1'b0;
            end
         end
         default: ;
      endcase
      s.lost = lost_bits;
      s.err  = err_bits;
      s.top  = top_chan;
      status_due.push_back(s);
   endfunction

   // Driver: record the accepted transaction, then load the next one or idle.
   always @(posedge clock) begin : drive_reqs
      logic          taken;
      watch_req_type r;
      if (reset) begin
         start <= 1'b0;
      end else begin
         taken = start && !busy;
         if (taken) begin
            r.op  = req_operation;
            r.ch  = req_channel;
            r.bad = req_data_bad;
            advance_watchdog(r);
         end
         if (!start || taken) begin
            if (pending_reqs.size() != 0 && (steady || $urandom_range(0, 99) >= 7)) begin
               r = pending_reqs.pop_front();
               start         <= 1'b1;
               req_operation <= r.op;
               req_channel   <= r.ch;
               req_data_bad  <= r.bad;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobe must match the oldest owed status, field by field.
   always @(posedge clock) begin : check_status
      status_type s;
      if (!reset && rsp_valid) begin
         if (status_due.size() == 0) begin
            $error("unexpected status: lost %h error %h top %0d",
                   rsp_lost_mask, rsp_error_mask, rsp_top_channel);
            errors_seen++;
         end else begin
            s = status_due.pop_front();
            if (rsp_lost_mask !== s.lost) begin
               $error("lost_mask: expected %h, actual %h", s.lost, rsp_lost_mask);
               errors_seen++;
            end
            if (rsp_error_mask !== s.err) begin
               $error("error_mask: expected %h, actual %h", s.err, rsp_error_mask);
               errors_seen++;
            end
            if (rsp_top_channel !== s.top) begin
               $error("top_channel: expected %0d, actual %0d", s.top, rsp_top_channel);
               errors_seen++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("multi_channel_liveness_monitor_tb: errors");
         $finish;
      end
   end

   function automatic void queue_item(logic [mclm_pkg::OP_BITS-1:0] op,
                                      logic [mclm_pkg::CH_BITS-1:0] ch,
                                      logic bad);
      watch_req_type r;
      r.op  = op;
      r.ch  = ch;
      r.bad = bad;
      pending_reqs.push_back(r);
   endfunction

   function automatic logic [63:0] rand_bytes(int maxv);
      logic [63:0] v;
      for (int b = 0; b < 8; b++)
         v[8*b +: 8] = 8'($urandom_range(0, maxv));
      return v;
   endfunction

   // Queue one short sequence; most are well formed (ticks then scan,
   // arrivals with an optional scan, reconnect then scan), the rest is noise.
   function automatic int queue_burst();
      int k;
      int cnt;
      cnt = 0;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            k = $urandom_range(0, 6);
            for (int i = 0; i < k; i++)
               queue_item(mclm_pkg::OP_TICK, 3'($urandom_range(0, 7)),
                          1'($urandom_range(0, 1)));
            queue_item(mclm_pkg::OP_SCAN, 3'($urandom_range(0, 7)),
                       1'($urandom_range(0, 1)));
            cnt = k + 1;
         end
         4, 5, 6: begin
            k = $urandom_range(1, 3);
            for (int i = 0; i < k; i++)
               queue_item(mclm_pkg::OP_ARRIVAL, 3'($urandom_range(0, 7)),
                          1'($urandom_range(0, 1)));
            cnt = k;
            if ($urandom_range(0, 1)) begin
               queue_item(mclm_pkg::OP_SCAN, 3'($urandom_range(0, 7)),
                          1'($urandom_range(0, 1)));
               cnt++;
            end
         end
         7: begin
            queue_item(mclm_pkg::OP_SCAN, 3'($urandom_range(0, 7)),
                       1'($urandom_range(0, 1)));
            cnt = 1;
         end
         8: begin
            queue_item(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                       1'($urandom_range(0, 1)));
            cnt = 1;
         end
         default: begin
            k = $urandom_range(0, 4);
            queue_item(mclm_pkg::OP_ARRIVAL, 3'($urandom_range(0, 7)),
                       1'($urandom_range(0, 1)));
            for (int i = 0; i < k; i++)
               queue_item(mclm_pkg::OP_TICK, '0, 1'b0);
            queue_item(mclm_pkg::OP_SCAN, '0, 1'b0);
            cnt = k + 2;
         end
      endcase
      return cnt;
   endfunction

   function automatic void queue_random(int target);
      int added;
      added = 0;
      while (added < target)
         added += queue_burst();
   endfunction

   // Hold until the driver is empty and every owed status has arrived.
   task automatic drain();
      while (pending_reqs.size() != 0 || start || status_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [mclm_pkg::CSR_IDX_BITS-1:0] idx,
                            logic [mclm_pkg::CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         mclm_pkg::REG_OFFLINE:
            offline_cfg = data[mclm_pkg::CHANNELS*mclm_pkg::LIMIT_BITS-1:0];
         mclm_pkg::REG_SETTLE:
            settle_cfg  = data[mclm_pkg::CHANNELS*mclm_pkg::LIMIT_BITS-1:0];
         mclm_pkg::REG_PRIO:
            prio_cfg    = data[mclm_pkg::CHANNELS*mclm_pkg::PRIO_BITS-1:0];
         mclm_pkg::REG_ENABLE:
            enable_cfg  = data[mclm_pkg::CHANNELS-1:0];
         mclm_pkg::REG_CHECK:
            check_cfg   = data[mclm_pkg::CHANNELS-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic write_all(logic [63:0] offl, logic [63:0] setl, logic [31:0] prio,
                            logic [7:0] en, logic [7:0] chk);
      write_reg(mclm_pkg::REG_OFFLINE, offl);
      write_reg(mclm_pkg::REG_SETTLE, setl);
      write_reg(mclm_pkg::REG_PRIO, 64'(prio));
      write_reg(mclm_pkg::REG_ENABLE, 64'(en));
      write_reg(mclm_pkg::REG_CHECK, 64'(chk));
   endtask

   initial begin : stimulus
      int steady_phase;
      reset_watchdog();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Default registers: reconnect a few channels, check the checked one bad.
      queue_item(mclm_pkg::OP_SCAN, 3'd0, 1'b0);
      queue_item(mclm_pkg::OP_ARRIVAL, 3'd2, 1'b1);
      queue_item(mclm_pkg::OP_ARRIVAL, 3'd3, 1'b1);
      queue_item(mclm_pkg::OP_ARRIVAL, 3'd0, 1'b0);
      queue_item(mclm_pkg::OP_TICK, 3'd7, 1'b1);
      queue_item(mclm_pkg::OP_SCAN, 3'd0, 1'b0);
      drain();

      // Directed: short limits, channel 7 disabled, low four channels checked.
      write_all(64'h0101_0101_0101_0101, 64'h0202_0202_0202_0202, 32'h0F12_3459,
                8'h7F, 8'h0F);
      for (int n = 0; n < mclm_pkg::CHANNELS; n++)
         queue_item(mclm_pkg::OP_ARRIVAL, 3'(n), 1'(n));
      queue_item(mclm_pkg::OP_SCAN, 3'd0, 1'b0);       // every enabled channel still settling
      queue_item(mclm_pkg::OP_TICK, 3'd0, 1'b0);
      queue_item(mclm_pkg::OP_ARRIVAL, 3'd0, 1'b0);
      queue_item(mclm_pkg::OP_ARRIVAL, 3'd1, 1'b1);
      queue_item(mclm_pkg::OP_TICK, 3'd0, 1'b0);
      queue_item(mclm_pkg::OP_ARRIVAL, 3'd0, 1'b0);
      queue_item(mclm_pkg::OP_ARRIVAL, 3'd1, 1'b0);
      queue_item(mclm_pkg::OP_SCAN, 3'd0, 1'b0);       // settle over on 0 and 1, channels 2 to 6 offline
      queue_item(OP_NONE, 3'd7, 1'b1);                 // unused code leaves status alone
      queue_item(mclm_pkg::OP_TICK, 3'd0, 1'b0);
      queue_item(mclm_pkg::OP_TICK, 3'd0, 1'b0);
      queue_item(mclm_pkg::OP_SCAN, 3'd0, 1'b0);
      drain();

      // All-zero limits and priorities: any tick takes a channel offline, no top.
      write_all(64'h0, 64'h0, 32'h0, 8'hFF, 8'hFF);
      queue_random(30);
      drain();

      // All-ones registers: nothing goes offline within this phase.
      write_all('1, '1, '1, 8'hFF, 8'hFF);
      queue_random(25);
      drain();

      // No channel monitored: scans must change nothing.
      write_all(rand_bytes(3), rand_bytes(3), $urandom, 8'h00, 8'($urandom_range(0, 255)));
      queue_random(20);
      drain();

      // Random registers with short limits; one phase runs without sender idling.
      steady_phase = $urandom_range(0, 3);
      for (int p = 0; p < 4; p++) begin
         write_all(rand_bytes(5), rand_bytes(4), $urandom, 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
         steady = (p == steady_phase);
         queue_random(45);
         drain();                            // pause sender until all status is back
         queue_random(40);
         drain();
      end
      steady = 1'b0;

      if (status_due.size() != 0) begin
         $error("%0d status results never arrived", status_due.size());
         errors_seen++;
      end
      if (errors_seen == 0)
         $display("multi_channel_liveness_monitor_tb: clean");
      else
         $display("multi_channel_liveness_monitor_tb: errors");
      $finish;
   end

endmodule
